// ----- hw/rtl/optp_pkg.sv -----
`default_nettype none
package optp_pkg;

   localparam int SCORE_W = 48;
   localparam int PRICE_W = 35;
   localparam int CAND_W  = 50;
   localparam int PRICE_IN_W = 32;
   localparam int LATENCY_W  = 3;
   localparam int LIMIT_W    = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [PRICE_W-1:0] price_type;
   typedef logic signed [CAND_W-1:0]  cand_type;

   localparam score_type SCORE_HI = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam score_type SCORE_LO = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef enum logic {
      CSR_POSITION_LIMIT = 1'b0,
      CSR_FEE            = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BP_HOLD_STAY,
      BP_HOLD_NEXT,
      BP_BUY,
      BP_SELL
   } bp_code_type;

   localparam logic signed [1:0] ACT_SELL = 2'sb11;
   localparam logic signed [1:0] ACT_HOLD = 2'sb00;
   localparam logic signed [1:0] ACT_BUY  = 2'sb01;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PRICE,
      ST_CAND,
      ST_MERGE,
      ST_SCAN,
      ST_TB_ISSUE,
      ST_TB_STEP,
      ST_TB_LAST
   } state_type;

   typedef struct packed {
      logic init;
      logic cand_en;
      logic merge_en;
   } cell_ctrl_type;

   function automatic score_type sat_score(input cand_type v);
      logic [CAND_W-SCORE_W:0] top;
      top = v[CAND_W-1:SCORE_W-1];
      if (top == '0 || top == '1) begin
         return v[SCORE_W-1:0];
      end else if (v[CAND_W-1]) begin
         return SCORE_LO;
      end else begin
         return SCORE_HI;
      end
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/optp_req_if.sv -----
`default_nettype none
interface optp_req_if #(parameter int IW = 10);
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic [optp_pkg::PRICE_IN_W-1:0]    mid_quote;
   logic [optp_pkg::PRICE_IN_W-1:0]    spread_half;
   logic [optp_pkg::LATENCY_W-1:0]     latency;
   logic                               last_sample;
   logic [IW-1:0]                      read_index;

   modport source (output valid, operation, mid_quote, spread_half, latency, last_sample,
                   read_index, input ready);
   modport sink (input valid, operation, mid_quote, spread_half, latency, last_sample,
                 read_index, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/optp_rsp_if.sv -----
`default_nettype none
interface optp_rsp_if #(parameter int IW = 10);
   logic                valid;
   logic                ready;
   logic signed [1:0]   action;
   logic [IW-1:0]       action_index;
   logic                last_action;
   logic                out_of_range;

   modport source (output valid, action, action_index, last_action, out_of_range,
                   input ready);
   modport sink (input valid, action, action_index, last_action, out_of_range,
                 output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/optp_cell.sv -----
`default_nettype none
module optp_cell #(
   parameter int WAITS = 8,
   parameter int WW    = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire optp_pkg::cell_ctrl_type ctrl,
   input  wire logic                    active,
   input  wire logic                    init_on,
   input  wire optp_pkg::price_type     buy_price,
   input  wire optp_pkg::price_type     sell_price,
   input  wire logic [WW-1:0]           lag,
   input  wire optp_pkg::score_type     lo_score,
   input  wire logic                    lo_valid,
   input  wire optp_pkg::score_type     hi_score,
   input  wire logic                    hi_valid,
   output optp_pkg::score_type          row_score [WAITS],
   output logic                         row_valid [WAITS],
   output optp_pkg::bp_code_type        code [WAITS]
);

   optp_pkg::score_type   s_ff  [WAITS];
   logic                  v_ff  [WAITS];
   optp_pkg::score_type   hs_ff [WAITS];
   logic                  hv_ff [WAITS];
   optp_pkg::bp_code_type hc_ff [WAITS];
   optp_pkg::bp_code_type c_ff  [WAITS];
   optp_pkg::score_type   buy_ff, sell_ff;
   logic                  buy_ok_ff, sell_ok_ff;
   logic                  stay0;

   // hold at wait zero: keep own slot only when strictly better
   assign stay0 = v_ff[0] && (!v_ff[1] || s_ff[0] > s_ff[1]);

   always_ff @(posedge clock) begin
      if (ctrl.cand_en) begin
         buy_ff     <= optp_pkg::sat_score(optp_pkg::CAND_W'(lo_score)
                                           - optp_pkg::CAND_W'(buy_price));
         sell_ff    <= optp_pkg::sat_score(optp_pkg::CAND_W'(hi_score)
                                           + optp_pkg::CAND_W'(sell_price));
         buy_ok_ff  <= lo_valid;
         sell_ok_ff <= hi_valid;
      end
   end

   for (genvar j = 0; j < WAITS; j++) begin : g_slot
      optp_pkg::score_type   ms;
      logic                  mv;
      optp_pkg::bp_code_type mc;

      if (j == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (ctrl.cand_en) begin
               hs_ff[j] <= stay0 ? s_ff[0] : s_ff[1];
               hv_ff[j] <= stay0 ? v_ff[0] : v_ff[1];
               hc_ff[j] <= stay0 ? optp_pkg::BP_HOLD_STAY : optp_pkg::BP_HOLD_NEXT;
            end
         end
      end else if (j + 1 < WAITS) begin : g_mid
         always_ff @(posedge clock) begin
            if (ctrl.cand_en) begin
               hs_ff[j] <= s_ff[j+1];
               hv_ff[j] <= v_ff[j+1];
               hc_ff[j] <= optp_pkg::BP_HOLD_NEXT;
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (ctrl.cand_en) begin
               hs_ff[j] <= s_ff[j];
               hv_ff[j] <= 1'b0;
               hc_ff[j] <= optp_pkg::BP_HOLD_NEXT;
            end
         end
      end

      always_comb begin
         ms = hs_ff[j];
         mv = hv_ff[j];
         mc = hc_ff[j];
         if (lag == WW'(j)) begin
            if (buy_ok_ff && (!mv || buy_ff > ms)) begin
               ms = buy_ff;
               mv = 1'b1;
               mc = optp_pkg::BP_BUY;
            end
            if (sell_ok_ff && (!mv || sell_ff >= ms)) begin
               ms = sell_ff;
               mv = 1'b1;
               mc = optp_pkg::BP_SELL;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (ctrl.init) begin
            v_ff[j] <= init_on && (j == 0);
         end else if (ctrl.merge_en) begin
            v_ff[j] <= mv && active;
         end
      end

      always_ff @(posedge clock) begin
         if (ctrl.init) begin
            s_ff[j] <= '0;
         end else if (ctrl.merge_en) begin
            s_ff[j] <= ms;
            c_ff[j] <= mc;
         end
      end

      assign row_score[j] = s_ff[j];
      assign row_valid[j] = v_ff[j];
      assign code[j]      = c_ff[j];
   end

endmodule
`default_nettype wire

// ----- hw/rtl/optimal_position_trellis_dp_top.sv -----
`default_nettype none
// Trellis optimiser for a trading position. Load beats (operation 0) fill the sample store
// one per cycle while req.ready is high; the beat with last_sample set starts the solve,
// during which req.ready is low. The solve runs a row of 2*MAX_POSITION+1 cells, one per
// position level, each holding MAX_LATENCY+2 wait slots and exchanging its wait-zero score
// with its neighbours; each sample passes through store read, price, candidate and merge,
// then a scan picks the flat end state and traceback walks the back pointer memory, one row
// per cycle. Read beats (operation 1) return one action each, in the cycle after acceptance,
// one beat in flight at a time. Configuration registers must be written only while the
// block is idle; the block itself does not enforce this.
module optimal_position_trellis_dp_top #(
   parameter int MAX_SAMPLES  = 1024,
   parameter int MAX_POSITION = 4,
   parameter int MAX_LATENCY  = 6
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   optp_req_if.sink                               req,
   optp_rsp_if.source                             rsp,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [optp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int LEVELS = 2 * MAX_POSITION + 1;
   localparam int WAITS  = MAX_LATENCY + 2;
   localparam int WW     = $clog2(WAITS);
   localparam int LVW    = $clog2(LEVELS);
   localparam int LW     = $clog2(MAX_POSITION + 1);
   localparam int IW     = $clog2(MAX_SAMPLES);
   localparam int CW     = $clog2(MAX_SAMPLES + 1);

   typedef optp_pkg::bp_code_type [LEVELS-1:0][WAITS-1:0] bp_row_type;

   // configuration
   logic [optp_pkg::LIMIT_W-1:0]    pos_limit_ff;
   logic [optp_pkg::PRICE_IN_W-1:0] fee_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_limit_ff <= optp_pkg::LIMIT_W'(1);
         fee_ff       <= '0;
      end else if (csr_we) begin
         unique case (optp_pkg::csr_index_type'(csr_index))
            optp_pkg::CSR_POSITION_LIMIT: pos_limit_ff <= csr_wdata[optp_pkg::LIMIT_W-1:0];
            optp_pkg::CSR_FEE:            fee_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   optp_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           done_ff, done_in;
   logic [LW-1:0]  lim_ff, lim_new;
   logic [IW-1:0]  step_ff, step_in;
   logic [IW-1:0]  tb_i_ff, tb_i_in;
   logic [WW-1:0]  scan_ff, scan_in;
   logic [LVW-1:0] cur_level_ff, cur_level_in;
   logic [WW-1:0]  cur_wait_ff, cur_wait_in;

   logic           req_fire, rsp_fire, load_fire, read_fire, start;
   logic [CW-1:0]  load_base;
   logic [WW-1:0]  lat_clamped;
   logic [IW-1:0]  last_step;

   // response
   logic           rsp_valid_ff;
   logic [IW-1:0]  rsp_idx_ff;
   logic           rsp_ok_ff, rsp_last_ff;
   logic [1:0]     act_rd_ff;

   // memories
   logic [optp_pkg::PRICE_IN_W-1:0] mid_mem    [MAX_SAMPLES];
   logic [optp_pkg::PRICE_IN_W-1:0] spread_mem [MAX_SAMPLES];
   logic [WW-1:0]                   wait_mem   [MAX_SAMPLES];
   logic [1:0]                      act_mem    [MAX_SAMPLES];
   bp_row_type                      bp_mem     [MAX_SAMPLES];

   logic [optp_pkg::PRICE_IN_W-1:0] mid_rd_ff, spread_rd_ff;
   logic [WW-1:0]                   wait_rd_ff;
   bp_row_type                      bp_rd_ff, bp_wdata;
   logic                            bp_we_ff;
   logic [IW-1:0]                   bp_waddr_ff, bp_raddr;
   logic                            act_we;
   logic [IW-1:0]                   act_waddr;
   logic [1:0]                      act_wdata;

   optp_pkg::price_type buy_price_ff, sell_price_ff;
   logic [WW-1:0]       lag_ff;

   // cells
   optp_pkg::cell_ctrl_type ctrl;
   optp_pkg::score_type     cs [LEVELS][WAITS];
   logic                    cv [LEVELS][WAITS];
   optp_pkg::bp_code_type   cc [LEVELS][WAITS];

   optp_pkg::bp_code_type   tb_code;
   logic signed [LVW:0]     lvl_diff;

   assign req.ready = (state_ff == optp_pkg::ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp_valid_ff && rsp.ready;
   assign load_fire = req_fire && (req.operation == optp_pkg::OP_LOAD);
   assign read_fire = req_fire && (req.operation == optp_pkg::OP_READ);
   assign start     = load_fire && req.last_sample;
   assign load_base = done_ff ? '0 : count_ff;
   assign last_step = IW'(count_ff - CW'(1));

   always_comb begin
      if (int'(req.latency) > MAX_LATENCY) begin
         lat_clamped = WW'(MAX_LATENCY);
      end else begin
         lat_clamped = WW'(req.latency);
      end
      if (pos_limit_ff == '0) begin
         lim_new = LW'(1);
      end else if (int'(pos_limit_ff) > MAX_POSITION) begin
         lim_new = LW'(MAX_POSITION);
      end else begin
         lim_new = LW'(pos_limit_ff);
      end
   end

   assign ctrl.init     = start;
   assign ctrl.cand_en  = (state_ff == optp_pkg::ST_CAND);
   assign ctrl.merge_en = (state_ff == optp_pkg::ST_MERGE);

   for (genvar k = 0; k < LEVELS; k++) begin : g_cell
      optp_pkg::score_type lo_s, hi_s;
      logic                lo_v, hi_v;
      logic                active, init_on;

      if (k == 0) begin : g_lo0
         assign lo_s = '0;
         assign lo_v = 1'b0;
      end else begin : g_lo
         assign lo_s = cs[k-1][0];
         assign lo_v = cv[k-1][0];
      end
      if (k == LEVELS - 1) begin : g_hiN
         assign hi_s = '0;
         assign hi_v = 1'b0;
      end else begin : g_hi
         assign hi_s = cs[k+1][0];
         assign hi_v = cv[k+1][0];
      end

      assign active  = k < 2 * int'(lim_ff) + 1;
      assign init_on = k == int'(lim_new);

      optp_cell #(.WAITS(WAITS), .WW(WW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .active     (active),
         .init_on    (init_on),
         .buy_price  (buy_price_ff),
         .sell_price (sell_price_ff),
         .lag        (lag_ff),
         .lo_score   (lo_s),
         .lo_valid   (lo_v),
         .hi_score   (hi_s),
         .hi_valid   (hi_v),
         .row_score  (cs[k]),
         .row_valid  (cv[k]),
         .code       (cc[k])
      );
   end

   always_comb begin
      for (int k = 0; k < LEVELS; k++) begin
         for (int j = 0; j < WAITS; j++) begin
            bp_wdata[k][j] = cc[k][j];
         end
      end
   end

   // sample store
   always_ff @(posedge clock) begin
      if (load_fire && load_base < CW'(MAX_SAMPLES)) begin
         mid_mem[load_base[IW-1:0]]    <= req.mid_quote;
         spread_mem[load_base[IW-1:0]] <= req.spread_half;
         wait_mem[load_base[IW-1:0]]   <= lat_clamped;
      end
      mid_rd_ff    <= mid_mem[step_ff];
      spread_rd_ff <= spread_mem[step_ff];
      wait_rd_ff   <= wait_mem[step_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == optp_pkg::ST_PRICE) begin
         buy_price_ff  <= optp_pkg::price_type'({3'b000, mid_rd_ff})
                          + optp_pkg::price_type'({3'b000, spread_rd_ff})
                          + optp_pkg::price_type'({3'b000, fee_ff});
         sell_price_ff <= optp_pkg::price_type'({3'b000, mid_rd_ff})
                          - optp_pkg::price_type'({3'b000, spread_rd_ff})
                          - optp_pkg::price_type'({3'b000, fee_ff});
         lag_ff        <= wait_rd_ff;
      end
   end

   // back pointer store
   assign bp_raddr = (state_ff == optp_pkg::ST_TB_STEP) ? tb_i_ff - IW'(1) : tb_i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_we_ff <= 1'b0;
      end else begin
         bp_we_ff <= (state_ff == optp_pkg::ST_MERGE);
      end
   end

   always_ff @(posedge clock) begin
      bp_waddr_ff <= step_ff;
      if (bp_we_ff) begin
         bp_mem[bp_waddr_ff] <= bp_wdata;
      end
      bp_rd_ff <= bp_mem[bp_raddr];
   end

   // traceback decode
   assign tb_code  = bp_rd_ff[cur_level_ff][cur_wait_ff];
   assign lvl_diff = $signed({1'b0, cur_level_ff}) - $signed({1'b0, LVW'(lim_ff)});

   always_comb begin
      act_we    = 1'b0;
      act_waddr = tb_i_ff;
      act_wdata = optp_pkg::ACT_HOLD;
      if (state_ff == optp_pkg::ST_TB_STEP) begin
         act_we = 1'b1;
         case (tb_code)
            optp_pkg::BP_BUY:  act_wdata = optp_pkg::ACT_BUY;
            optp_pkg::BP_SELL: act_wdata = optp_pkg::ACT_SELL;
            default:           act_wdata = optp_pkg::ACT_HOLD;
         endcase
      end else if (state_ff == optp_pkg::ST_TB_LAST) begin
         act_we    = 1'b1;
         act_waddr = '0;
         act_wdata = lvl_diff[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
      if (read_fire) begin
         act_rd_ff <= act_mem[req.read_index];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= optp_pkg::ST_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      tb_i_ff      <= tb_i_in;
      scan_ff      <= scan_in;
      cur_level_ff <= cur_level_in;
      cur_wait_ff  <= cur_wait_in;
      if (start) begin
         lim_ff <= lim_new;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      step_in      = step_ff;
      tb_i_in      = tb_i_ff;
      scan_in      = scan_ff;
      cur_level_in = cur_level_ff;
      cur_wait_in  = cur_wait_ff;
      unique case (state_ff)
         optp_pkg::ST_IDLE: begin
            if (load_fire) begin
               done_in  = 1'b0;
               count_in = (load_base < CW'(MAX_SAMPLES)) ? load_base + CW'(1) : load_base;
               if (req.last_sample) begin
                  state_in = optp_pkg::ST_FETCH;
                  step_in  = '0;
               end
            end
         end
         optp_pkg::ST_FETCH: state_in = optp_pkg::ST_PRICE;
         optp_pkg::ST_PRICE: state_in = optp_pkg::ST_CAND;
         optp_pkg::ST_CAND:  state_in = optp_pkg::ST_MERGE;
         optp_pkg::ST_MERGE: begin
            if (step_ff == last_step) begin
               state_in     = optp_pkg::ST_SCAN;
               scan_in      = WW'(1);
               cur_wait_in  = '0;
               cur_level_in = LVW'(lim_ff);
            end else begin
               state_in = optp_pkg::ST_FETCH;
               step_in  = step_ff + IW'(1);
            end
         end
         optp_pkg::ST_SCAN: begin
            if (cv[cur_level_ff][scan_ff]
                && cs[cur_level_ff][scan_ff] > cs[cur_level_ff][cur_wait_ff]) begin
               cur_wait_in = scan_ff;
            end
            scan_in = scan_ff + WW'(1);
            if (scan_ff == WW'(WAITS - 1)) begin
               tb_i_in  = last_step;
               state_in = (last_step == '0) ? optp_pkg::ST_TB_LAST : optp_pkg::ST_TB_ISSUE;
            end
         end
         optp_pkg::ST_TB_ISSUE: state_in = optp_pkg::ST_TB_STEP;
         optp_pkg::ST_TB_STEP: begin
            case (tb_code)
               optp_pkg::BP_BUY: begin
                  cur_level_in = cur_level_ff - LVW'(1);
                  cur_wait_in  = '0;
               end
               optp_pkg::BP_SELL: begin
                  cur_level_in = cur_level_ff + LVW'(1);
                  cur_wait_in  = '0;
               end
               optp_pkg::BP_HOLD_STAY: cur_wait_in = '0;
               default:                cur_wait_in = cur_wait_ff + WW'(1);
            endcase
            tb_i_in = tb_i_ff - IW'(1);
            if (tb_i_ff == IW'(1)) begin
               state_in = optp_pkg::ST_TB_LAST;
            end
         end
         optp_pkg::ST_TB_LAST: begin
            state_in = optp_pkg::ST_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = optp_pkg::ST_IDLE;
      endcase
   end

   // response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (read_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (read_fire) begin
         rsp_idx_ff  <= req.read_index;
         rsp_ok_ff   <= done_ff && (CW'(req.read_index) < count_ff);
         rsp_last_ff <= done_ff && (CW'(req.read_index) + CW'(1) == count_ff);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.action       = rsp_ok_ff ? act_rd_ff : optp_pkg::ACT_HOLD;
   assign rsp.action_index = rsp_idx_ff;
   assign rsp.last_action  = rsp_last_ff;
   assign rsp.out_of_range = !rsp_ok_ff;

endmodule
`default_nettype wire

// ----- test/tb_optimal_position_trellis_dp_top.sv -----
`timescale 1ns / 1ps
module tb_optimal_position_trellis_dp_top;

   localparam int DEPTH     = 1024;
   localparam int POS_MAX   = 4;
   localparam int LAT_MAX   = 6;
   localparam int SLOTS     = (2 * POS_MAX + 1) * (LAT_MAX + 2);
   localparam int LIMIT_CYC = 900000;
   localparam longint SC_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SC_LO = -SC_HI - 1;

   typedef struct {
      logic signed [1:0] action;
      logic [9:0]        index;
      logic              last;
      logic              oor;
   } action_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [optp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   optp_req_if #(.IW(10)) req_ch ();
   optp_rsp_if #(.IW(10)) rsp_ch ();

   optimal_position_trellis_dp_top dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [2:0]  lim_reg;
   logic [31:0] fee_reg;
   logic [31:0] smp_mid [DEPTH];
   logic [31:0] smp_spr [DEPTH];
   int          smp_wait [DEPTH];
   int          smp_n, wait_top, solved_n;
   bit          solved;
   logic signed [1:0] actions [DEPTH];
   longint      row_sc [2][SLOTS];
   bit          row_ok [2][SLOTS];
   shortint unsigned bp_mem [DEPTH][SLOTS];

   action_beat_type pending_actions[$];
   int  errors = 0;
   int  cycles = 0;
   bit  calm_req = 0, calm_rsp = 0;

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYC) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic longint clip(longint v);
      if (v > SC_HI) return SC_HI;
      if (v < SC_LO) return SC_LO;
      return v;
   endfunction

   function automatic void solve_trellis();
      int lim, nl, nd, i, k, j, p, c, b, src, dst, lag, cur, prv;
      longint m, g, f, price, cand;
      lim = lim_reg;
      if (lim < 1) lim = 1;
      if (lim > POS_MAX) lim = POS_MAX;
      nl = 2 * lim + 1;
      nd = wait_top + 2;
      f = longint'(fee_reg);
      foreach (row_ok[0][s]) row_ok[0][s] = 0;
      m = longint'(smp_mid[0]);
      g = longint'(smp_spr[0]);
      row_sc[0][lim*nd] = 0;
      row_ok[0][lim*nd] = 1;
      row_sc[0][(lim-1)*nd + smp_wait[0]] = clip(m - g - f);
      row_ok[0][(lim-1)*nd + smp_wait[0]] = 1;
      row_sc[0][(lim+1)*nd + smp_wait[0]] = clip(-m - g - f);
      row_ok[0][(lim+1)*nd + smp_wait[0]] = 1;
      for (i = 1; i < smp_n; i++) begin
         p = (i - 1) & 1;
         c = i & 1;
         m = longint'(smp_mid[i]);
         g = longint'(smp_spr[i]);
         lag = smp_wait[i];
         foreach (row_ok[0][s]) row_ok[c][s] = 0;
         for (k = 0; k < nl; k++) begin
            b = k * nd;
            if (row_ok[p][b] && (!row_ok[p][b+1] || row_sc[p][b] > row_sc[p][b+1])) src = b;
            else src = b + 1;
            row_sc[c][b] = row_sc[p][src];
            row_ok[c][b] = row_ok[p][src];
            bp_mem[i][b] = src;
            for (j = 1; j + 1 < nd; j++) begin
               row_sc[c][b+j] = row_sc[p][b+j+1];
               row_ok[c][b+j] = row_ok[p][b+j+1];
               bp_mem[i][b+j] = b + j + 1;
            end
         end
         price = m + g + f;
         for (k = 1; k < nl; k++) begin
            src = (k - 1) * nd;
            dst = k * nd + lag;
            if (row_ok[p][src]) begin
               cand = clip(row_sc[p][src] - price);
               if (!row_ok[c][dst] || cand > row_sc[c][dst]) begin
                  row_sc[c][dst] = cand;
                  row_ok[c][dst] = 1;
                  bp_mem[i][dst] = src;
               end
            end
         end
         price = m - g - f;
         for (k = 0; k + 1 < nl; k++) begin
            src = (k + 1) * nd;
            dst = k * nd + lag;
            if (row_ok[p][src]) begin
               cand = clip(row_sc[p][src] + price);
               if (!row_ok[c][dst] || cand >= row_sc[c][dst]) begin
                  row_sc[c][dst] = cand;
                  row_ok[c][dst] = 1;
                  bp_mem[i][dst] = src;
               end
            end
         end
      end
      p = (smp_n - 1) & 1;
      cur = lim * nd;
      for (j = lim * nd + 1; j < (lim + 1) * nd; j++)
         if (row_ok[p][j] && row_sc[p][j] > row_sc[p][cur]) cur = j;
      for (i = smp_n - 1; i > 0; i--) begin
         prv = bp_mem[i][cur];
         actions[i] = 2'(cur / nd - prv / nd);
         cur = prv;
      end
      actions[0] = 2'(cur / nd - lim);
   endfunction

   function automatic void predict(optp_pkg::op_type op, logic [31:0] mid, logic [31:0] spr,
                                   logic [2:0] lat, logic last, logic [9:0] idx);
      action_beat_type e;
      int w;
      bit ok;
      if (op == optp_pkg::OP_LOAD) begin
         if (solved) begin
            smp_n = 0;
            wait_top = 0;
            solved = 0;
         end
         if (smp_n < DEPTH) begin
            w = (lat > LAT_MAX) ? LAT_MAX : lat;
            smp_mid[smp_n] = mid;
            smp_spr[smp_n] = spr;
            smp_wait[smp_n] = w;
            if (w > wait_top) wait_top = w;
            smp_n++;
         end
         if (last && smp_n > 0) begin
            solve_trellis();
            solved = 1;
            solved_n = smp_n;
         end
      end else begin
         ok = solved && idx < smp_n;
         e.action = ok ? actions[idx] : optp_pkg::ACT_HOLD;
         e.index = idx;
         e.last = ok && (idx + 1 == smp_n);
         e.oor = !ok;
         pending_actions = {pending_actions, e};
      end
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      action_beat_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_actions.size() == 0) begin
            report("unexpected beat", rsp_ch.action_index, -1);
         end else begin
            e = pending_actions.pop_front();
            if (rsp_ch.action !== e.action) report("action", rsp_ch.action, e.action);
            if (rsp_ch.action_index !== e.index)
               report("action_index", rsp_ch.action_index, e.index);
            if (rsp_ch.last_action !== e.last) report("last_action", rsp_ch.last_action, e.last);
            if (rsp_ch.out_of_range !== e.oor) report("out_of_range", rsp_ch.out_of_range, e.oor);
         end
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = calm_rsp ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
      end
   end

   task automatic send(optp_pkg::op_type op, logic [31:0] mid, logic [31:0] spr,
                       logic [2:0] lat, logic last, logic [9:0] idx);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.mid_quote <= mid;
      req_ch.spread_half <= spr;
      req_ch.latency <= lat;
      req_ch.last_sample <= last;
      req_ch.read_index <= idx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict(op, mid, spr, lat, last, idx);
   endtask

   task automatic load(logic [31:0] mid, logic [31:0] spr, logic [2:0] lat, logic last);
      send(optp_pkg::OP_LOAD, mid, spr, lat, last, 10'($urandom));
   endtask

   task automatic read(logic [9:0] idx);
      send(optp_pkg::OP_READ, $urandom, $urandom, 3'($urandom), 1'($urandom), idx);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (6 * solved_n + LAT_MAX + 40) @(posedge clock);
      solved_n = 0;
   endtask

   task automatic csr_write(optp_pkg::csr_index_type r, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(posedge clock);
      if (r == optp_pkg::CSR_POSITION_LIMIT) lim_reg = v[2:0];
      else fee_reg = v;
   endtask

   task automatic configure(logic [2:0] lim, logic [31:0] fee);
      settle();
      csr_write(optp_pkg::CSR_POSITION_LIMIT, 32'(lim));
      csr_write(optp_pkg::CSR_FEE, fee);
      csr_we <= 1'b0;
   endtask

   task automatic random_sample(bit last);
      logic [31:0] mid, spr;
      if ($urandom_range(0, 9) == 0) begin
         mid = $urandom;
         spr = $urandom;
      end else begin
         mid = 32'h0064_0000 + $urandom_range(0, 32'h0008_0000);
         spr = $urandom_range(0, 32'h0000_4000);
      end
      load(mid, spr, 3'($urandom), last);
   endtask

   task automatic test_read_before_solve();
      read(10'd0);
      read(10'h3FF);
   endtask

   task automatic test_extremes();
      configure(3'd4, 32'd0);
      load(32'd0, 32'd0, 3'd0, 1'b0);
      load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b0);
      load(32'h0001_0000, 32'd0, 3'd6, 1'b0);
      load(32'h0000_8000, 32'd0, 3'd1, 1'b0);
      load(32'hFFFF_FFFF, 32'd0, 3'd0, 1'b1);
      for (int i = 0; i <= 5; i++) read(10'(i));
      read(10'h3FF);
      // single sample set, limit clamps
      configure(3'd0, 32'hFFFF_FFFF);
      load(32'h5555_5555, 32'hAAAA_AAAA, 3'd5, 1'b1);
      read(10'd0);
      read(10'd1);
      configure(3'd7, 32'd1);
      load(32'd10, 32'd0, 3'd2, 1'b0);
      load(32'd40, 32'd0, 3'd0, 1'b0);
      load(32'd5, 32'd0, 3'd3, 1'b1);
      for (int i = 0; i < 3; i++) read(10'(i));
   endtask

   task automatic test_store_full();
      configure(3'd2, 32'h0000_0100);
      calm_req = 1;
      for (int i = 0; i < DEPTH + 6; i++) random_sample(i == DEPTH + 5);
      calm_req = 0;
      read(10'd0);
      read(10'd1022);
      read(10'h3FF);
      for (int i = 0; i < 6; i++) read(10'($urandom));
   endtask

   task automatic test_random_sets();
      int len, nreads;
      for (int set = 0; set < 6; set++) begin
         if (set % 2 == 0) begin
            configure(3'($urandom_range(0, 7)),
                      ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h2000));
            calm_req = (set % 4 == 0);
            calm_rsp = (set % 3 == 0);
         end
         if ($urandom_range(0, 5) == 0) read(10'($urandom));
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 20);
         for (int i = 0; i < len; i++) random_sample(i == len - 1);
         nreads = $urandom_range(3, 12);
         for (int i = 0; i < nreads; i++)
            read(($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, len)));
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = optp_pkg::OP_LOAD;
      req_ch.mid_quote = '0;
      req_ch.spread_half = '0;
      req_ch.latency = '0;
      req_ch.last_sample = 1'b0;
      req_ch.read_index = '0;
      lim_reg = 3'd1;
      fee_reg = '0;
      smp_n = 0;
      wait_top = 0;
      solved_n = 0;
      solved = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_read_before_solve();
      test_extremes();
      test_store_full();
      test_random_sets();
      settle();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
